// ===== rtl/sobel_edge_magnitude_unit_macros.svh =====
// Assertion macros shared by the checker.
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sem_pkg.sv =====
package sem_pkg;

  localparam int MaxWidthDef  = 2048;
  localparam int MaxHeightDef = 4096;
  localparam int SumW         = 10;
  localparam int GradW        = 13;
  localparam int SqW          = 25;
  localparam int RootW        = 13;

  localparam logic [0:0] RegFrameWidth  = 1'b0;
  localparam logic [0:0] RegFrameHeight = 1'b1;

  // Front-to-back record: the 3x3 window plus the frame-last flag.
  typedef struct packed {
    logic [8:0][SumW-1:0] win;
    logic                 last;
  } sem_win_t;

  // Square root state encoding; the pipelined sem_back does not use it.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_DONE
  } sem_state_t;

endpackage

// ===== rtl/sobel_edge_magnitude_unit.sv =====
// Sobel edge magnitude over a raster RGB pixel stream.
// Input channel s_axis: one pixel per transaction, tdata = {blue, green, red}
// (red in bits 7:0). Output channel m_axis: one result per interior pixel,
// tdata holds edge_magnitude, tlast marks the last interior pixel of a frame.
// Border pixels give no output transaction.
// Configuration: cfg_we writes frame_width (index 0) or frame_height (index 1);
// write only while no pixel is in flight.
// Throughput: one pixel per clock, sustained while m_axis_tready stays high. The front end reads and writes
// both line stores (one RAM port each) per pixel; the back end is a fully
// pipelined root extractor with one result bit per stage.
// Path: a pixel that completes a window passes stage 1, the window register,
// the gradient, square, root and divide registers and the queue to m_axis.
// Reset: counters clear, so the next pixel is the top-left pixel of a frame;
// sizes return to 640 x 480. Line stores are not cleared.
// When m_axis_tready is low, results collect in a two-entry queue and the
// back pipeline, then the front end, then s_axis_tready stall in turn.
module sobel_edge_magnitude_unit #(
  parameter int MaxWidth  = sem_pkg::MaxWidthDef,
  parameter int MaxHeight = sem_pkg::MaxHeightDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // red_value, green_value, blue_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // edge_magnitude
  output logic        m_axis_tlast   // frame_last
);

  logic [11:0] frame_width;
  logic [12:0] frame_height;
  logic              win_valid;
  logic              win_ready;
  sem_pkg::sem_win_t win_data;

  // Hold size registers; the user must write them only between frames (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 12'd640;
      frame_height <= 13'd480;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sem_pkg::RegFrameWidth:  frame_width  <= cfg_data[11:0];
        sem_pkg::RegFrameHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  sem_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .red_value   (s_axis_tdata[7:0]),
    .green_value (s_axis_tdata[15:8]),
    .blue_value  (s_axis_tdata[23:16]),
    .win_valid   (win_valid),
    .win_data    (win_data),
    .win_ready   (win_ready)
  );

  sem_back u_back (
    .clk      (clk),
    .rst      (rst),
    .win_valid(win_valid),
    .win_ready(win_ready),
    .win_data (win_data),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res_mag  (m_axis_tdata),
    .res_last (m_axis_tlast)
  );

endmodule

// ===== rtl/sem_ram.sv =====
module sem_ram #(
  parameter int Width = 10,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sem_front.sv =====
module sem_front #(
  parameter int MaxWidth  = sem_pkg::MaxWidthDef,
  parameter int MaxHeight = sem_pkg::MaxHeightDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [11:0]       frame_width,
  input  logic [12:0]       frame_height,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        red_value,
  input  logic [7:0]        green_value,
  input  logic [7:0]        blue_value,
  output logic              win_valid,
  output sem_pkg::sem_win_t win_data,
  input  logic              win_ready
);

  localparam int AW = $clog2(MaxWidth);
  localparam int CW = $clog2(MaxWidth + 1);
  localparam int RW = $clog2(MaxHeight + 1);
  localparam int SW = sem_pkg::SumW;

  // Stage 1: address the line stores; stage 2: shift the window.
  logic          s1_valid;
  logic [SW-1:0] s1_sum;
  logic          s1_emit;
  logic          s1_last;
  logic [AW-1:0] s1_idx;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [CW-1:0] col_next;
  logic [RW-1:0] row_next;
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  logic [AW-1:0] idx;
  logic [AW-1:0] rd_idx;
  logic          last_col;
  logic          last_row;
  logic [SW-1:0] prev1;
  logic [SW-1:0] prev2;
  logic [8:0][SW-1:0] win;
  logic          take;
  logic          advance;

  // Stalls only when the output record is held.
  assign advance  = !win_valid || win_ready;
  assign in_ready = advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    if (frame_width < 12'd3) begin
      eff_w = CW'(3);
    end else if ({{(32-12){1'b0}}, frame_width} > 32'(MaxWidth)) begin
      eff_w = CW'(MaxWidth);
    end else begin
      eff_w = CW'(frame_width);
    end
    if (frame_height < 13'd3) begin
      eff_h = RW'(3);
    end else if ({{(32-13){1'b0}}, frame_height} > 32'(MaxHeight)) begin
      eff_h = RW'(MaxHeight);
    end else begin
      eff_h = RW'(frame_height);
    end
  end

  assign idx      = (32'(col) < 32'(MaxWidth)) ? col[AW-1:0] : AW'(MaxWidth - 1);
  assign last_col = (32'(col) + 32'd1) >= 32'(eff_w);
  assign last_row = (32'(row) + 32'd1) >= 32'(eff_h);

  // Re-read the waiting pixel's address while stage 1 is held, so the
  // line store data stays valid until the pixel advances.
  assign rd_idx = take ? idx : s1_idx;

  always_comb begin
    col_next = col;
    row_next = row;
    if (last_col) begin
      col_next = '0;
      row_next = last_row ? '0 : row + RW'(1);
    end else begin
      col_next = col + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= take;
      end
      if (take) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sum  <= SW'(red_value) + SW'(green_value) + SW'(blue_value);
      s1_idx  <= idx;
      s1_emit <= (32'(col) >= 32'd2) && (32'(row) >= 32'd2);
      s1_last <= last_col && last_row;
    end
  end

  // Read at accept, write back at stage 1: same address on back-to-back pixels
  // is impossible since consecutive pixels have distinct columns (width >= 3).
  sem_ram #(.Width(SW), .Depth(MaxWidth)) u_line_a (
    .clk  (clk),
    .we   (s1_valid && advance),
    .waddr(s1_idx),
    .wdata(s1_sum),
    .raddr(rd_idx),
    .rdata(prev1)
  );

  sem_ram #(.Width(SW), .Depth(MaxWidth)) u_line_b (
    .clk  (clk),
    .we   (s1_valid && advance),
    .waddr(s1_idx),
    .wdata(prev1),
    .raddr(rd_idx),
    .rdata(prev2)
  );

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= prev2;
      win[5] <= prev1;
      win[8] <= s1_sum;
    end
  end

  // Window output is combinational off the shifted window register.
  logic emit_q;
  logic last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_q <= 1'b0;
    end else if (advance) begin
      emit_q <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      last_q <= s1_last;
    end
  end

  assign win_valid     = emit_q;
  assign win_data.win  = win;
  assign win_data.last = last_q;

endmodule

// ===== rtl/sem_fifo.sv =====
module sem_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_mag,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_mag,
  output logic              out_last
);

  // Two-entry queue before the sink; while full it takes no new entry, even as it pops.
  logic [1:0][8:0] mem;
  logic            rd_ptr;
  logic            wr_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_mag   = mem[rd_ptr][7:0];
  assign out_last  = mem[rd_ptr][8];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {in_last, in_mag};
    end
  end

endmodule

// ===== rtl/sem_back.sv =====
module sem_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              win_valid,
  output logic              win_ready,
  input  sem_pkg::sem_win_t win_data,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [7:0]        res_mag,
  output logic              res_last
);

  localparam int GW = sem_pkg::GradW;
  localparam int QW = sem_pkg::SqW;
  localparam int RT = sem_pkg::RootW;
  localparam int NSTEP = 13;

  // Pipeline: gradients, squares, root digits (one per stage), divide by 3.
  // All stages advance together; a stall freezes the whole chain.
  logic adv;
  logic [2:0] v;
  logic signed [GW-1:0] gx;
  logic signed [GW-1:0] gy;
  logic [11:0] ax;
  logic [11:0] ay;
  logic [QW-1:0] sq;
  logic last1;
  logic last2;
  logic [NSTEP:0] rv;
  logic [NSTEP:0][QW-1:0] rem;
  logic [NSTEP:0][RT-1:0] root;
  logic [NSTEP:0] rl;
  logic dv;
  logic [7:0] dmag;
  logic dlast;
  logic [RT+13:0] prod;
  logic [RT-1:0] q3;
  logic fifo_ready;

  logic [8:0][sem_pkg::SumW-1:0] q;
  assign q = win_data.win;

  always_comb begin
    gx = (GW'(q[2]) + (GW'(q[5]) <<< 1) + GW'(q[8]))
       - (GW'(q[0]) + (GW'(q[3]) <<< 1) + GW'(q[6]));
    gy = (GW'(q[6]) + (GW'(q[7]) <<< 1) + GW'(q[8]))
       - (GW'(q[0]) + (GW'(q[1]) <<< 1) + GW'(q[2]));
  end

  assign adv       = fifo_ready || !dv;
  assign win_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v  <= '0;
      rv <= '0;
      dv <= 1'b0;
    end else if (adv) begin
      v[0] <= win_valid;
      v[1] <= v[0];
      rv[0] <= v[1];
      for (int i = 1; i <= NSTEP; i++) begin
        rv[i] <= rv[i-1];
      end
      dv <= rv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ax    <= 12'(gx < 0 ? -gx : gx);
      ay    <= 12'(gy < 0 ? -gy : gy);
      last1 <= win_data.last;
      sq    <= QW'(ax * ax) + QW'(ay * ay);
      last2 <= last1;
      rem[0]  <= sq;
      root[0] <= '0;
      rl[0]   <= last2;
    end
  end

  // One result bit per stage, restoring method, bit 12 down to bit 0.
  for (genvar i = 0; i < NSTEP; i++) begin : g_root
    localparam int B = NSTEP - 1 - i;
    logic [QW+1:0] t;
    assign t = ({2'b0, QW'(root[i])} << (B + 1)) + ((QW+2)'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (adv) begin
        rl[i+1] <= rl[i];
        if ({2'b0, rem[i]} >= t) begin
          rem[i+1]  <= rem[i] - QW'(t);
          root[i+1] <= root[i] | RT'(1 << B);
        end else begin
          rem[i+1]  <= rem[i];
          root[i+1] <= root[i];
        end
      end
    end
  end

  // floor(x/3) for x < 8192 as (x * 2731) >> 13.
  assign prod = (RT+14)'(root[NSTEP]) * (RT+14)'(2731);
  assign q3   = RT'(prod >> 13);

  always_ff @(posedge clk) begin
    if (adv) begin
      dmag  <= (q3 > RT'(255)) ? 8'd255 : q3[7:0];
      dlast <= rl[NSTEP];
    end
  end

  sem_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dv),
    .in_ready (fifo_ready),
    .in_mag   (dmag),
    .in_last  (dlast),
    .out_valid(res_valid),
    .out_ready(res_ready),
    .out_mag  (res_mag),
    .out_last (res_last)
  );

endmodule

// ===== rtl/sem_checker.sv =====
`include "sobel_edge_magnitude_unit_macros.svh"

module sem_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  `SEM_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")
  `SEM_ASSERT_NEXT(a_no_out_after_reset, clk, rst, $fell(rst), !m_axis_tvalid, "result right after reset")
  `SEM_ASSERT_IMP(a_ready_when_idle, clk, rst, !m_axis_tvalid && $past(!m_axis_tvalid, 30), s_axis_tready, "input stalled with empty output")

endmodule

bind sobel_edge_magnitude_unit sem_checker u_sem_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
